>>> hdl/md5_pkg.sv
`default_nettype none
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } md5_in_t;

  typedef struct packed {
    logic [63:0] digest_low;
    logic [63:0] digest_high;
  } md5_out_t;

  // queue entry between front and back: a full block or a padded block; last marks the final one
  typedef struct packed {
    logic [511:0] block;
    logic         last;
  } md5_job_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C = 32'h98BADCFE;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;

  localparam logic [31:0] STEP_CONST [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam logic [4:0] ROT_AMOUNT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

endpackage
`default_nettype wire

>>> hdl/md5_front.sv
`default_nettype none
// collects bytes into a block buffer, pads at end of message, pushes blocks
module md5_front (
  input  wire              clk,
  input  wire              rst,
  input  md5_pkg::md5_in_t in_item,
  input  wire              in_valid,
  output logic             in_stall,
  output md5_pkg::md5_job_t job,
  output logic             job_valid,
  input  wire              job_stall
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    ST_FILL = 3'b001,
    ST_PAD  = 3'b010,
    ST_PUSH = 3'b100
  } front_state_t;

  front_state_t state;
  logic [511:0] block;
  logic [5:0]   fill_position;
  logic [63:0]  message_bit_count;
  logic [63:0]  len_bits;
  logic         job_last;
  logic         pad_first;
  logic         pad_last;
  logic         padding;
  logic         push_done;

  assign in_stall  = (state != ST_FILL);
  assign job_valid = (state == ST_PUSH);
  assign job.block = block;
  assign job.last  = job_last;
  assign push_done = !job_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      fill_position <= '0;
      message_bit_count <= '0;
      job_last <= 1'b0;
      pad_first <= 1'b0;
      pad_last <= 1'b0;
      padding <= 1'b0;
    end else begin
      case (state)
        ST_FILL: begin
          if (in_valid) begin
            if (in_item.byte_present) begin
              block[{fill_position, 3'b000} +: 8] <= in_item.data_byte;
              fill_position <= fill_position + 6'd1;
              message_bit_count <= message_bit_count + 64'd8;
            end
            len_bits <= message_bit_count + (in_item.byte_present ? 64'd8 : 64'd0);
            pad_first <= 1'b1;
            if (in_item.byte_present && fill_position == 6'd63) begin
              // full block goes out first, padding follows if the message ended
              job_last <= 1'b0;
              padding <= in_item.end_of_message;
              state <= ST_PUSH;
            end else if (in_item.end_of_message) begin
              padding <= 1'b1;
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          // one pad byte per cycle: 0x80, zeros, then the length
          if (pad_first) begin
            block[{fill_position, 3'b000} +: 8] <= PAD_BYTE;
            pad_last <= (fill_position < LEN_POS);
          end else if (pad_last && fill_position >= LEN_POS) begin
            block[{fill_position, 3'b000} +: 8] <=
              len_bits[{fill_position[2:0], 3'b000} +: 8];
          end else begin
            block[{fill_position, 3'b000} +: 8] <= 8'h00;
          end
          pad_first <= 1'b0;
          fill_position <= fill_position + 6'd1;
          if (fill_position == 6'd63) begin
            job_last <= !pad_first && pad_last;
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push_done) begin
            if (job_last) begin
              message_bit_count <= '0;
              padding <= 1'b0;
              state <= ST_FILL;
            end else if (padding) begin
              // the next block is the one that carries the length
              pad_last <= 1'b1;
              state <= ST_PAD;
            end else begin
              state <= ST_FILL;
            end
          end
        end
        default: state <= ST_FILL;
      endcase
    end
  end

  // a block whose 0x80 lands at position 56 or later gets zeros to its end and
  // is not last; the length then goes into the following all-zero block
endmodule
`default_nettype wire

>>> hdl/md5_back.sv
`default_nettype none
// one md5 step per cycle on a queued block, updates chain, emits digest
module md5_back (
  input  wire               clk,
  input  wire               rst,
  input  md5_pkg::md5_job_t job,
  input  wire               job_valid,
  output logic              job_stall,
  output md5_pkg::md5_out_t out_item,
  output logic              out_valid,
  input  wire               out_stall
);
  import md5_pkg::*;

  logic [31:0] chain [4];
  logic [31:0] a, b, c, d;
  logic [511:0] blk;
  logic        blk_last;
  logic        busy;
  logic [5:0]  step;
  logic [1:0]  rnd;
  logic [3:0]  g;
  logic [31:0] f, w, t, rot;
  logic [4:0]  s;
  logic [31:0] ca, cb, cc, cd;

  assign job_stall = busy || out_valid;

  always_comb begin
    rnd = step[5:4];
    case (rnd)
      2'd0: begin f = (b & c) | (~b & d); g = step[3:0]; end
      2'd1: begin f = (b & d) | (c & ~d); g = 4'(5 * step + 1); end
      2'd2: begin f = b ^ c ^ d; g = 4'(3 * step + 5); end
      default: begin f = c ^ (b | ~d); g = 4'(7 * step); end
    endcase
    w = blk[{g, 5'b00000} +: 32];
    s = ROT_AMOUNT[{rnd, step[1:0]}];
    t = a + f + w + STEP_CONST[step];
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
    ca = chain[0] + d;
    cb = chain[1] + b + rot;
    cc = chain[2] + b;
    cd = chain[3] + c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      chain[0] <= INIT_A; chain[1] <= INIT_B;
      chain[2] <= INIT_C; chain[3] <= INIT_D;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (!busy && !out_valid && job_valid) begin
        busy <= 1'b1;
        blk <= job.block;
        blk_last <= job.last;
        step <= '0;
        a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3];
      end else if (busy) begin
        a <= d; d <= c; c <= b; b <= b + rot;
        step <= step + 6'd1;
        if (step == 6'd63) begin
          busy <= 1'b0;
          if (blk_last) begin
            out_item.digest_low  <= {cb, ca};
            out_item.digest_high <= {cd, cc};
            out_valid <= 1'b1;
            chain[0] <= INIT_A; chain[1] <= INIT_B;
            chain[2] <= INIT_C; chain[3] <= INIT_D;
          end else begin
            chain[0] <= ca; chain[1] <= cb; chain[2] <= cc; chain[3] <= cd;
          end
        end
      end
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> job_stall) else $error("job taken while busy");
  a_step_reset: assert property (@(posedge clk) disable iff (rst)
    (!busy && job_valid && !job_stall) |=> (busy && step == 6'd0))
    else $error("step not cleared at start");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("digest dropped");
endmodule
`default_nettype wire

>>> hdl/md5_message_digest.sv
`default_nettype none
// channel  | direction | payload   | handshake
// in_item  | in        | md5_in_t  | in_valid / in_stall
// out_item | out       | md5_out_t | out_valid / out_stall
// one byte per cycle while filling; each full block runs through the
// compression unit one step per cycle, overlapped with filling the next block
// end of message pads one byte per cycle then waits for the back part
// reset clears fill count, bit count and chain words; block buffer is not cleared
// a stalled digest blocks the compression unit, which then stalls block hand-off
module md5_message_digest (
  input  wire               clk,
  input  wire               rst,
  input  md5_pkg::md5_in_t  in_item,
  input  wire               in_valid,
  output logic              in_stall,
  output md5_pkg::md5_out_t out_item,
  output logic              out_valid,
  input  wire               out_stall
);
  import md5_pkg::*;

  md5_job_t job;
  logic     job_valid;
  logic     job_stall;

  md5_front u_front (
    .clk(clk), .rst(rst), .in_item(in_item), .in_valid(in_valid),
    .in_stall(in_stall), .job(job), .job_valid(job_valid), .job_stall(job_stall)
  );

  md5_back u_back (
    .clk(clk), .rst(rst), .job(job), .job_valid(job_valid), .job_stall(job_stall),
    .out_item(out_item), .out_valid(out_valid), .out_stall(out_stall)
  );
endmodule
`default_nettype wire
